FILE: src/ssdc_pkg.sv
// Shared types and constants for the seven-segment digit classifier.
// Holds the pixel and result word structs, segment codes and digit patterns.
// No dependencies.
`timescale 1ns / 1ps

package ssdc_pkg;

    localparam int DIM_W           = 9;
    localparam int PIXEL_W         = 8;
    localparam int DIGIT_W         = 4;
    localparam int SEG_N           = 7;
    localparam int NUM_DIGITS      = 10;
    localparam int DEFAULT_MAX_DIM = 256;

    localparam logic [PIXEL_W-1:0] LIT_VALUE = 8'd255;

    // Floor of v/3 for v below 512 is (v * 171) >> 9.
    localparam int              THIRD_W     = 8;
    localparam logic [THIRD_W-1:0] THIRD_MULT = 8'd171;
    localparam int              THIRD_SHIFT = 9;

    localparam logic [SEG_N-1:0] SEG_A = 7'h01;
    localparam logic [SEG_N-1:0] SEG_B = 7'h02;
    localparam logic [SEG_N-1:0] SEG_C = 7'h04;
    localparam logic [SEG_N-1:0] SEG_D = 7'h08;
    localparam logic [SEG_N-1:0] SEG_E = 7'h10;
    localparam logic [SEG_N-1:0] SEG_F = 7'h20;
    localparam logic [SEG_N-1:0] SEG_G = 7'h40;

    localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 4'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 4'd0;

    typedef struct packed {
        logic [DIM_W-1:0]   region_width;
        logic [DIM_W-1:0]   region_height;
        logic [PIXEL_W-1:0] pixel_value;
    } pixel_word_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               recognized;
        logic [SEG_N-1:0]   segment_flags;
    } result_word_t;

    // Segment pattern of each digit; the entry for one is never matched.
    function automatic logic [SEG_N-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
        logic [SEG_N-1:0] p;
        case (d)
            4'd0:    p = 7'h3F;
            4'd2:    p = 7'h5B;
            4'd3:    p = 7'h4F;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6D;
            4'd6:    p = 7'h7D;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7F;
            4'd9:    p = 7'h6F;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

endpackage

FILE: src/ssdc_decode.sv
// Maps the segment flags of a finished region to a digit.
// Depends on ssdc_pkg for the result word and the digit patterns.
`timescale 1ns / 1ps

module ssdc_decode
    import ssdc_pkg::*;
(
    input  logic [SEG_N-1:0] flags,
    input  logic             tall,
    output result_word_t     result
);

    always_comb
    begin
        result.digit         = DIGIT_NONE;
        result.recognized    = 1'b0;
        result.segment_flags = flags;
        if (tall)
        begin
            result.digit      = DIGIT_ONE;
            result.recognized = 1'b1;
        end
        else
        begin
            // Patterns are distinct, so at most one entry matches.
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                if (DIGIT_W'(k) != DIGIT_ONE && digit_pattern(DIGIT_W'(k)) == flags)
                begin
                    result.digit      = DIGIT_W'(k);
                    result.recognized = 1'b1;
                end
            end
        end
    end

endmodule

FILE: src/seven_segment_digit_classifier.sv
// Top level of the seven-segment digit classifier.
// Depends on ssdc_pkg and ssdc_decode.
`timescale 1ns / 1ps

// Usage:
// The pixel channel (pixel_valid, pixel_stall, pixel) takes one word per pixel of a
// binarized digit region in raster order; each word carries the region's width and
// height. Row and column counters track the position and lit pixels on the crossing
// lines set segment flags.
// The result channel (result_valid, result_stall, result) gives one word for the last
// pixel of each region: the digit, a recognized bit and the segment flags seen.
// Pixels that are not the last of a region give no result.
// A pixel taken is registered in the input register; once it is the last of its region
// and the result register is free, its result is loaded there and result_valid rises.
// Throughput: one pixel per cycle when not stalled. The result register is freed in
// the same cycle it is taken, so one-pixel regions also run at one word per cycle.
// When result_stall holds a result, pixels keep flowing until a region's last pixel
// reaches the input register; then pixel_stall rises until the result is taken.
// Reset clears both valid flags, the counters and the segment flags.
module seven_segment_digit_classifier
    import ssdc_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pixel_valid,
    output logic         pixel_stall,
    input  pixel_word_t  pixel,
    output logic         result_valid,
    input  logic         result_stall,
    output result_word_t result
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;

    logic             in_valid_reg, in_valid_next;
    pixel_word_t      in_word_reg;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [SEG_N-1:0] seen_reg, seen_next;
    logic             out_valid_reg, out_valid_next;
    result_word_t     out_word_reg;

    logic [DIM_W-1:0]         w, h;
    logic [DIM_W-2:0]         half;
    logic [DIM_W+THIRD_W-1:0] third_prod;
    logic [THIRD_W-1:0]       third;
    logic [CMP_W-1:0]         col_x, row_x, w_x, h_x, half_x, third_x, two_third_x;
    logic [DIM_W+1:0]         w3;
    logic [CNT_W:0]           row_inc;
    logic                     lit, row_end, is_last, tall;
    logic                     out_free, advance, accept;
    logic [SEG_N-1:0]         hits;
    result_word_t             decoded;

    // Size clamp: zero counts as one, anything above MAX_DIM as MAX_DIM.
    always_comb
    begin
        w = in_word_reg.region_width;
        h = in_word_reg.region_height;
        if (w == '0)
            w = DIM_W'(1);
        else if (32'(w) > MAX_DIM)
            w = DIM_W'(MAX_DIM);
        if (h == '0)
            h = DIM_W'(1);
        else if (32'(h) > MAX_DIM)
            h = DIM_W'(MAX_DIM);
    end

    assign half        = w[DIM_W-1:1];
    assign third_prod  = (DIM_W+THIRD_W)'(h) * (DIM_W+THIRD_W)'(THIRD_MULT);
    assign third       = third_prod[THIRD_SHIFT+THIRD_W-1:THIRD_SHIFT];
    assign col_x       = CMP_W'(col_reg);
    assign row_x       = CMP_W'(row_reg);
    assign w_x         = CMP_W'(w);
    assign h_x         = CMP_W'(h);
    assign half_x      = CMP_W'(half);
    assign third_x     = CMP_W'(third);
    assign two_third_x = CMP_W'({third, 1'b0});
    assign w3          = (DIM_W+2)'(w) + (DIM_W+2)'({w, 1'b0});
    assign tall        = w3 < (DIM_W+2)'(h);
    assign lit         = in_word_reg.pixel_value == LIT_VALUE;
    assign row_end     = col_x >= (w_x - CMP_W'(1));
    assign is_last     = row_end && (row_x >= (h_x - CMP_W'(1)));

    always_comb
    begin
        hits = '0;
        if (lit)
        begin
            if (col_x == half_x)
            begin
                if (row_x < third_x)
                    hits = hits | SEG_A;
                else if (row_x < two_third_x)
                    hits = hits | SEG_G;
                else
                    hits = hits | SEG_D;
            end
            if (row_x == third_x)
                hits = hits | ((col_x < half_x) ? SEG_F : SEG_B);
            if (row_x == two_third_x)
                hits = hits | ((col_x < half_x) ? SEG_E : SEG_C);
        end
    end

    ssdc_decode u_decode
    (
        .flags  (seen_reg | hits),
        .tall   (tall),
        .result (decoded)
    );

    // A pixel that ends no region can move on even while a result is held.
    assign out_free    = !out_valid_reg || !result_stall;
    assign advance     = in_valid_reg && (!is_last || out_free);
    assign pixel_stall = in_valid_reg && !advance;
    assign accept      = pixel_valid && !pixel_stall;
    assign row_inc     = (CNT_W+1)'(row_reg) + (CNT_W+1)'(1);

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (advance)
            in_valid_next = 1'b0;
        if (accept)
            in_valid_next = 1'b1;
        if (advance)
        begin
            if (is_last)
            begin
                col_next       = '0;
                row_next       = '0;
                seen_next      = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                seen_next = seen_reg | hits;
                if (row_end)
                begin
                    col_next = '0;
                    if (row_inc < (CNT_W+1)'(MAX_DIM))
                        row_next = row_inc[CNT_W-1:0];
                end
                else
                begin
                    col_next = col_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_word_reg <= pixel;
        if (advance && is_last)
            out_word_reg <= decoded;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

`ifndef SYNTHESIS
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> in_valid_reg)
        else $error("pixel_stall raised with an empty input register");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(advance && is_last))
        else $error("result appeared without a region's last pixel");

    a_clear_after_region: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_last |=> col_reg == '0 && row_reg == '0 && seen_reg == '0)
        else $error("counters or flags not cleared after a region");

    a_unrecognized_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.recognized |-> result.digit == DIGIT_NONE)
        else $error("digit nonzero on an unrecognized region");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the seven-segment digit classifier: directed and random pixel streams.
// Each region's result word is predicted and checked. Depends on ssdc_pkg and the block.
module tb_top;
    import ssdc_pkg::*;

    localparam int RANDOM_PIXELS = 1650;
    localparam int QUIET_PIXELS  = 250;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 25;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_LIMIT   = 20000;

    localparam logic [SEG_N-1:0] GLYPH [NUM_DIGITS] = '{
        7'h3F, 7'h00, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct {
        pixel_word_t  word;
        bit           typed;
        result_word_t want;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         pixel_valid;
    logic         pixel_stall;
    pixel_word_t  pixel;
    logic         result_valid;
    logic         result_stall;
    result_word_t result;

    stim_row_t        directed_rows[$];
    result_word_t     pending_digits[$];
    int               scan_col;
    int               scan_row;
    logic [SEG_N-1:0] seg_seen;
    int               pixels_sent;
    int               digits_taken;
    int               failures;
    int               quiet_at;
    bit               quiet;

    seven_segment_digit_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("%s", what);
        end
    endfunction

    function automatic int clamp_size(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > DEFAULT_MAX_DIM)
        begin
            return DEFAULT_MAX_DIM;
        end
        return int'(v);
    endfunction

    // Segments that a lit pixel at this position would set.
    function automatic logic [SEG_N-1:0] crossing_hits(input int col, input int row,
                                                       input int w, input int h);
        int               half;
        int               third;
        logic [SEG_N-1:0] hits;
        half  = w / 2;
        third = h / 3;
        hits  = '0;
        if (col == half)
        begin
            if (row < third)
                hits |= SEG_A;
            else if (row < 2 * third)
                hits |= SEG_G;
            else
                hits |= SEG_D;
        end
        if (row == third)
            hits |= (col < half) ? SEG_F : SEG_B;
        if (row == 2 * third)
            hits |= (col < half) ? SEG_E : SEG_C;
        return hits;
    endfunction

    function automatic logic [PIXEL_W-1:0] dark_level();
        if ($urandom_range(0, 1) == 0)
        begin
            return '0;
        end
        return PIXEL_W'($urandom_range(0, 254));
    endfunction

    task automatic classify_pixel(input pixel_word_t word, output bit done,
                                  output result_word_t res);
        int w;
        int h;
        int d;
        bit row_end;
        bit last;
        w       = clamp_size(word.region_width);
        h       = clamp_size(word.region_height);
        row_end = scan_col >= w - 1;
        last    = row_end && scan_row >= h - 1;
        if (word.pixel_value == LIT_VALUE)
            seg_seen |= crossing_hits(scan_col, scan_row, w, h);
        res  = '0;
        done = last;
        if (!last)
        begin
            if (row_end)
            begin
                scan_col = 0;
                if (scan_row + 1 < DEFAULT_MAX_DIM)
                    scan_row++;
            end
            else
            begin
                scan_col++;
            end
        end
        else
        begin
            res.segment_flags = seg_seen;
            res.digit         = DIGIT_NONE;
            res.recognized    = 1'b0;
            if (3 * w < h)
            begin
                res.digit      = DIGIT_ONE;
                res.recognized = 1'b1;
            end
            else
            begin
                for (d = 0; d < NUM_DIGITS; d++)
                begin
                    if (d != int'(DIGIT_ONE) && !res.recognized && GLYPH[d] == seg_seen)
                    begin
                        res.digit      = DIGIT_W'(d);
                        res.recognized = 1'b1;
                    end
                end
            end
            scan_col = 0;
            scan_row = 0;
            seg_seen = '0;
        end
    endtask

    task automatic send_pixel(input pixel_word_t word, input bit typed,
                              input result_word_t want);
        bit           done;
        result_word_t res;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= word;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        classify_pixel(word, done, res);
        if (done)
            pending_digits.insert(pending_digits.size(), typed ? want : res);
        pixels_sent++;
        quiet = pixels_sent >= quiet_at;
    endtask

    // Draws a region in raster order; lit crossings stay within the target segments except for rare random flips.
    task automatic send_region(input int wf, input int hf, input logic [SEG_N-1:0] target);
        int               w;
        int               h;
        int               r;
        int               c;
        bit               lit;
        logic [SEG_N-1:0] hits;
        pixel_word_t      word;
        w                  = clamp_size(wf[DIM_W-1:0]);
        h                  = clamp_size(hf[DIM_W-1:0]);
        word.region_width  = wf[DIM_W-1:0];
        word.region_height = hf[DIM_W-1:0];
        for (r = 0; r < h; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                hits = crossing_hits(c, r, w, h);
                if (hits != '0)
                    lit = (hits & ~target) == '0;
                else
                    lit = $urandom_range(0, 3) == 0;
                if ($urandom_range(0, 49) == 0)
                    lit = !lit;
                word.pixel_value = lit ? LIT_VALUE : dark_level();
                send_pixel(word, 1'b0, '0);
            end
        end
    endtask

    function automatic void add_row(input int wf, input int hf, input int pv,
                                    input bit typed = 1'b0,
                                    input logic [DIGIT_W-1:0] digit = DIGIT_NONE,
                                    input logic recog = 1'b0,
                                    input logic [SEG_N-1:0] flags = '0);
        stim_row_t row;
        row.word.region_width   = wf[DIM_W-1:0];
        row.word.region_height  = hf[DIM_W-1:0];
        row.word.pixel_value    = pv[PIXEL_W-1:0];
        row.typed               = typed;
        row.want.digit          = digit;
        row.want.recognized     = recog;
        row.want.segment_flags  = flags;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    always @(posedge clk)
    begin : result_check
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            digits_taken++;
            if (pending_digits.size() == 0)
            begin
                note_failure($sformatf("unexpected result: digit %0d recognized %0b flags %h",
                                       result.digit, result.recognized, result.segment_flags));
            end
            else
            begin
                want = pending_digits.pop_front();
                if (result.digit !== want.digit || result.recognized !== want.recognized
                    || result.segment_flags !== want.segment_flags)
                begin
                    note_failure($sformatf(
                        "mismatch: expected digit %0d recognized %0b flags %h, got %0d %0b %h",
                        want.digit, want.recognized, want.segment_flags,
                        result.digit, result.recognized, result.segment_flags));
                end
            end
        end
    end

    // Result side: short random stalls, one long hold to back the block up, none at the end.
    initial
    begin : result_drain
        int  hold;
        bit  held;
        held = 1'b0;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && digits_taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                for (hold = 0; hold < HOLD_CYCLES; hold++)
                    @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int               pick;
        int               wf;
        int               hf;
        int               n;
        int               stop_at;
        int               drain;
        logic [SEG_N-1:0] target;
        pixel_word_t      word;

        rst_n        <= 1'b0;
        pixel_valid  <= 1'b0;
        pixel        <= '0;
        scan_col     = 0;
        scan_row     = 0;
        seg_seen     = '0;
        pixels_sent  = 0;
        digits_taken = 0;
        failures     = 0;
        quiet_at     = 32'h7FFF_FFFF;
        quiet        = 1'b0;

        // One dark pixel region right after reset: nothing seen, nothing matched.
        add_row(1, 1, 0, 1'b1, DIGIT_NONE, 1'b0, '0);
        // Zero size is taken as one; the lone lit pixel sits on both crossing rows.
        add_row(0, 0, 255, 1'b1, DIGIT_NONE, 1'b0, SEG_B | SEG_C | SEG_D);
        // Oversize width, then the size shrinks within the region.
        add_row(511, 1, 255);
        add_row(1, 1, 254);
        // Oversize height, then the size shrinks within the region.
        add_row(1, 511, 255);
        add_row(1, 1, 8'hAA);
        // A region much taller than wide is a one.
        add_row(1, 4, 0);
        add_row(1, 4, 0);
        add_row(1, 4, 0);
        add_row(1, 4, 0, 1'b1, DIGIT_ONE, 1'b1, '0);
        // Short region: row zero serves as both crossing rows.
        repeat (4) add_row(2, 2, 255);
        // Fully lit three by three region shows all seven segments.
        repeat (8) add_row(3, 3, 255);
        add_row(3, 3, 255, 1'b1, 4'd8, 1'b1, 7'h7F);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        stop_at  = pixels_sent + RANDOM_PIXELS;
        quiet_at = stop_at - QUIET_PIXELS;
        while (pixels_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // Noise: arbitrary sizes and values, often breaking the current region.
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    word.region_width  = DIM_W'($urandom_range(0, 511));
                    word.region_height = DIM_W'($urandom_range(0, 511));
                    word.pixel_value   = ($urandom_range(0, 1) == 0) ? LIT_VALUE
                                         : PIXEL_W'($urandom_range(0, 255));
                    send_pixel(word, 1'b0, '0);
                end
            end
            else
            begin
                // A one-pixel region word closes whatever region is still open.
                if (scan_col != 0 || scan_row != 0)
                begin
                    word.region_width  = DIM_W'(1);
                    word.region_height = DIM_W'(1);
                    word.pixel_value   = PIXEL_W'($urandom_range(0, 255));
                    send_pixel(word, 1'b0, '0);
                end
                if ($urandom_range(0, 4) == 0)
                    target = SEG_N'($urandom_range(0, 127));
                else
                    target = GLYPH[$urandom_range(0, NUM_DIGITS - 1)];
                if (pick < 9)
                begin
                    wf = $urandom_range(200, 511);
                    hf = $urandom_range(0, 1);
                end
                else if (pick < 10)
                begin
                    wf = $urandom_range(0, 1);
                    hf = $urandom_range(100, 511);
                end
                else if (pick < 25)
                begin
                    wf = $urandom_range(0, 2);
                    hf = $urandom_range(0, 3);
                end
                else
                begin
                    wf = $urandom_range(1, 6);
                    hf = $urandom_range(1, 9);
                end
                send_region(wf, hf, target);
            end
        end
        pixel_valid <= 1'b0;

        drain = 0;
        while (pending_digits.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (pending_digits.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   pending_digits.size()));

        if (failures == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
